[hdl/fqm_pkg.sv]
// fqm_pkg: shared types and constants of the queued mutex table
// used by fifo_queued_mutex_table_unit; depends on nothing else

package fqm_pkg;

   // field widths of the request and response words
   localparam int KIND_W   = 1;
   localparam int LOCK_W   = 4;
   localparam int THREAD_W = 4;
   localparam int STATUS_W = 2;

   // default table sizes
   localparam int NUM_LOCKS_DEF   = 16;
   localparam int NUM_THREADS_DEF = 16;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ACQUIRE = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 2'd0,
      ST_QUEUED  = 2'd1,
      ST_HANDED  = 2'd2,
      ST_FREED   = 2'd3
   } status_type;

endpackage

[hdl/fifo_queued_mutex_table_unit.sv]
// fifo_queued_mutex_table_unit: table of mutexes with per-lock fifo wait queues
// depends on fqm_pkg for field widths, operation and status codes
//
// Usage:
//   A request word (req_kind, req_lock_index, req_thread_id) is taken at a
//   rising edge where start is high and busy is low. Acquire grants a free
//   lock or one already held by the requester, else appends the requester to
//   the lock's wait queue. Release hands the lock to the head waiter and wakes
//   it, or frees the lock when nobody waits; the caller is not checked.
//   Lock and thread ids are reduced modulo the table sizes.
//   Each request yields exactly one response word, shown on the rsp_ ports for
//   one cycle with rsp_valid high: the request is registered, then the table
//   lookup and update run combinationally into the response register. A new
//   request may be taken every cycle, since the table state is written at the
//   same edge that loads the response.
//   The receiver cannot stall; rsp_valid is a one-cycle strobe.
//   Reset clears lock-held, queue-nonempty, link-valid and waiting flags;
//   busy is high during reset and for one cycle after it.

module fifo_queued_mutex_table_unit
   import fqm_pkg::*;
#(
   parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
   parameter int NUM_THREADS = NUM_THREADS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [LOCK_W-1:0]   req_lock_index,
   input  logic [THREAD_W-1:0] req_thread_id,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_woken_valid,
   output logic [THREAD_W-1:0] rsp_woken_thread,
   output logic [THREAD_W-1:0] rsp_owner_thread
);

   localparam int LW       = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int TW       = $clog2(NUM_THREADS);
   localparam int LOCK_IDS = 1 << LOCK_W;
   localparam int THR_IDS  = 1 << THREAD_W;

   // id reduction tables, constant after elaboration
   logic [LW-1:0] lock_map [LOCK_IDS];
   logic [TW-1:0] thr_map  [THR_IDS];

   for (genvar i = 0; i < LOCK_IDS; i++) begin : g_lock_map
      assign lock_map[i] = LW'(i % NUM_LOCKS);
   end
   for (genvar i = 0; i < THR_IDS; i++) begin : g_thr_map
      assign thr_map[i] = TW'(i % NUM_THREADS);
   end

   // request register
   logic                req_valid_ff;
   kind_type            req_kind_ff;
   logic [LW-1:0]       req_lock_ff;
   logic [TW-1:0]       req_thread_ff;
   logic                busy_ff;

   // per-lock tables
   logic [TW-1:0] owner_ff [NUM_LOCKS];
   logic [TW-1:0] owner_in [NUM_LOCKS];
   logic [TW-1:0] head_ff  [NUM_LOCKS];
   logic [TW-1:0] head_in  [NUM_LOCKS];
   logic [TW-1:0] tail_ff  [NUM_LOCKS];
   logic [TW-1:0] tail_in  [NUM_LOCKS];
   logic [NUM_LOCKS-1:0] held_ff, held_in;
   logic [NUM_LOCKS-1:0] qne_ff, qne_in;

   // per-thread tables
   logic [TW-1:0] link_ff [NUM_THREADS];
   logic [TW-1:0] link_in [NUM_THREADS];
   logic [NUM_THREADS-1:0] link_vld_ff, link_vld_in;
   logic [NUM_THREADS-1:0] waiting_ff, waiting_in;

   // response register
   logic                rsp_valid_ff;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_woken_ff, rsp_woken_in;
   logic [TW-1:0]       rsp_wthr_ff, rsp_wthr_in;
   logic [TW-1:0]       rsp_owner_ff, rsp_owner_in;

   // lookups of the registered request
   logic [TW-1:0] cur_owner, cur_head, cur_tail, head_link;
   logic          cur_held, cur_qne, head_link_vld;

   assign cur_owner     = owner_ff[req_lock_ff];
   assign cur_head      = head_ff[req_lock_ff];
   assign cur_tail      = tail_ff[req_lock_ff];
   assign cur_held      = held_ff[req_lock_ff];
   assign cur_qne       = qne_ff[req_lock_ff];
   assign head_link     = link_ff[cur_head];
   assign head_link_vld = link_vld_ff[cur_head];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         qne_ff       <= '0;
         link_vld_ff  <= '0;
         waiting_ff   <= '0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
         rsp_valid_ff <= req_valid_ff;
         held_ff      <= held_in;
         qne_ff       <= qne_in;
         link_vld_ff  <= link_vld_in;
         waiting_ff   <= waiting_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_kind_ff   <= kind_type'(req_kind);
         req_lock_ff   <= lock_map[req_lock_index];
         req_thread_ff <= thr_map[req_thread_id];
      end
      owner_ff      <= owner_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      link_ff       <= link_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
      rsp_wthr_ff   <= rsp_wthr_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   // table update and response for the registered request
   always_comb begin
      owner_in      = owner_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      held_in       = held_ff;
      qne_in        = qne_ff;
      link_in       = link_ff;
      link_vld_in   = link_vld_ff;
      waiting_in    = waiting_ff;
      rsp_status_in = ST_GRANTED;
      rsp_woken_in  = 1'b0;
      rsp_wthr_in   = '0;
      rsp_owner_in  = '0;
      if (req_valid_ff) begin
         if (req_kind_ff == KIND_ACQUIRE) begin
            if (!cur_held || cur_owner == req_thread_ff) begin
               // free or re-entrant: grant
               held_in[req_lock_ff]  = 1'b1;
               owner_in[req_lock_ff] = req_thread_ff;
               rsp_status_in         = ST_GRANTED;
               rsp_owner_in          = req_thread_ff;
            end else begin
               // contended: append to the wait queue once
               if (!waiting_ff[req_thread_ff]) begin
                  link_vld_in[req_thread_ff] = 1'b0;
                  if (!cur_qne) begin
                     head_in[req_lock_ff] = req_thread_ff;
                     qne_in[req_lock_ff]  = 1'b1;
                  end else begin
                     link_in[cur_tail]     = req_thread_ff;
                     link_vld_in[cur_tail] = 1'b1;
                  end
                  tail_in[req_lock_ff]      = req_thread_ff;
                  waiting_in[req_thread_ff] = 1'b1;
               end
               rsp_status_in = ST_QUEUED;
               rsp_owner_in  = cur_owner;
            end
         end else if (cur_qne) begin
            // hand the lock to the head waiter
            owner_in[req_lock_ff] = cur_head;
            held_in[req_lock_ff]  = 1'b1;
            waiting_in[cur_head]  = 1'b0;
            if (head_link_vld) begin
               head_in[req_lock_ff] = head_link;
            end else begin
               qne_in[req_lock_ff] = 1'b0;
            end
            link_vld_in[cur_head] = 1'b0;
            rsp_status_in         = ST_HANDED;
            rsp_woken_in          = 1'b1;
            rsp_wthr_in           = cur_head;
            rsp_owner_in          = cur_head;
         end else begin
            // nobody waits: free the lock
            held_in[req_lock_ff] = 1'b0;
            rsp_status_in        = ST_FREED;
         end
      end
   end

   // outputs
   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_woken_valid  = rsp_woken_ff;
   assign rsp_woken_thread = THREAD_W'(rsp_wthr_ff);
   assign rsp_owner_thread = THREAD_W'(rsp_owner_ff);

   // checks
   a_woken_iff_handed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_woken_valid == (rsp_status == ST_HANDED)))
      else $error("woken flag disagrees with status");

   a_woken_owns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_valid |-> rsp_owner_thread == rsp_woken_thread)
      else $error("woken thread is not the new owner");

   a_freed_no_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FREED |-> rsp_owner_thread == '0)
      else $error("freed lock reports an owner");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("accepted word gave no response");

endmodule

[bench/fifo_queued_mutex_table_unit_tb.sv]
// fifo_queued_mutex_table_unit_tb: self-checking bench for the queued mutex table
// needs fqm_pkg and fifo_queued_mutex_table_unit; directed words, then random
// contention bursts and noise, each response checked against a lock table model
`timescale 1ns / 1ps

module fifo_queued_mutex_table_unit_tb
   import fqm_pkg::*;
;

   localparam int LIMIT_NS      = 1_000_000;
   localparam int RANDOM_WORDS  = 1700;
   localparam int CALM_TAIL     = 250;
   localparam int DRAIN_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 8;

   // one expected response word
   typedef struct {
      status_type          status;
      logic                woken_valid;
      logic [THREAD_W-1:0] woken_thread;
      logic [THREAD_W-1:0] owner_thread;
   } lock_outcome_type;

   // mirror of the lock table plus the queue of outcomes still to come back
   class lock_table_checker;
      bit [THREAD_W-1:0] owner_of[NUM_LOCKS_DEF];
      bit                held[NUM_LOCKS_DEF];
      bit [THREAD_W-1:0] head[NUM_LOCKS_DEF];
      bit [THREAD_W-1:0] tail[NUM_LOCKS_DEF];
      bit                has_waiters[NUM_LOCKS_DEF];
      int                waiters[NUM_LOCKS_DEF];
      bit [THREAD_W-1:0] behind[NUM_THREADS_DEF];
      bit                behind_ok[NUM_THREADS_DEF];
      bit                is_waiting[NUM_THREADS_DEF];
      lock_outcome_type  pending_outcomes[$];
      int                failures;
      int                shown;
      int                checked;
      int                status_seen[4];
      int                longest_queue;

      // work out the outcome of an accepted word and advance the table
      function void note_request(kind_type op, logic [LOCK_W-1:0] lock_in,
                                 logic [THREAD_W-1:0] thread_in);
         lock_outcome_type o;
         int l;
         int t;
         int w;
         l = int'(lock_in) % NUM_LOCKS_DEF;
         t = int'(thread_in) % NUM_THREADS_DEF;
         o.woken_valid  = 1'b0;
         o.woken_thread = '0;
         o.owner_thread = '0;
         if (op == KIND_ACQUIRE) begin
            if (!held[l] || owner_of[l] == t) begin
               held[l]        = 1'b1;
               owner_of[l]    = THREAD_W'(t);
               o.status       = ST_GRANTED;
               o.owner_thread = THREAD_W'(t);
            end else begin
               // a thread already parked somewhere is not queued twice
               if (!is_waiting[t]) begin
                  behind_ok[t] = 1'b0;
                  if (!has_waiters[l]) begin
                     head[l]        = THREAD_W'(t);
                     has_waiters[l] = 1'b1;
                  end else begin
                     behind[tail[l]]    = THREAD_W'(t);
                     behind_ok[tail[l]] = 1'b1;
                  end
                  tail[l]       = THREAD_W'(t);
                  is_waiting[t] = 1'b1;
                  waiters[l]++;
                  if (waiters[l] > longest_queue) longest_queue = waiters[l];
               end
               o.status       = ST_QUEUED;
               o.owner_thread = owner_of[l];
            end
         end else if (has_waiters[l]) begin
            // hand over to the head waiter, whoever asked for the release
            w             = int'(head[l]);
            owner_of[l]   = THREAD_W'(w);
            held[l]       = 1'b1;
            is_waiting[w] = 1'b0;
            if (behind_ok[w]) head[l] = behind[w];
            else has_waiters[l] = 1'b0;
            behind_ok[w] = 1'b0;
            waiters[l]--;
            o.status       = ST_HANDED;
            o.woken_valid  = 1'b1;
            o.woken_thread = THREAD_W'(w);
            o.owner_thread = THREAD_W'(w);
         end else begin
            held[l]  = 1'b0;
            o.status = ST_FREED;
         end
         status_seen[o.status]++;
         pending_outcomes.push_back(o);
      endfunction

      // compare one response word with the oldest outcome
      function void check_response(logic [STATUS_W-1:0] status, logic woken_valid,
                                   logic [THREAD_W-1:0] woken_thread,
                                   logic [THREAD_W-1:0] owner_thread);
         lock_outcome_type o;
         checked++;
         if (pending_outcomes.size() == 0) begin
            failures++;
            if (shown < 10) begin
               shown++;
               $display("unexpected response word: status %0d woken %0b/%0d owner %0d",
                        status, woken_valid, woken_thread, owner_thread);
            end
            return;
         end
         o = pending_outcomes.pop_front();
         if (status !== o.status || woken_valid !== o.woken_valid ||
             woken_thread !== o.woken_thread || owner_thread !== o.owner_thread) begin
            failures++;
            if (shown < 10) begin
               shown++;
               $display("response %0d mismatch: expected status %0d woken %0b/%0d owner %0d,",
                        checked, o.status, o.woken_valid, o.woken_thread, o.owner_thread);
               $display("   got status %0d woken %0b/%0d owner %0d",
                        status, woken_valid, woken_thread, owner_thread);
            end
         end
      endfunction

      function int owner_now(int l);
         return held[l] ? int'(owner_of[l]) : $urandom_range(0, NUM_THREADS_DEF - 1);
      endfunction
   endclass

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind       = KIND_ACQUIRE;
   logic [LOCK_W-1:0]   req_lock_index = '0;
   logic [THREAD_W-1:0] req_thread_id  = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_woken_valid;
   logic [THREAD_W-1:0] rsp_woken_thread;
   logic [THREAD_W-1:0] rsp_owner_thread;

   lock_table_checker lock_model = new();
   int  words_sent;
   int  acquires_sent;
   bit  gaps_on;

   fifo_queued_mutex_table_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_lock_index   (req_lock_index),
      .req_thread_id    (req_thread_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread),
      .rsp_owner_thread (rsp_owner_thread)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response words are sampled on the edge that ends their cycle
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         lock_model.check_response(rsp_status, rsp_woken_valid, rsp_woken_thread,
                                   rsp_owner_thread);
   end

   // present one word, with an optional gap before it, and wait until taken
   task automatic send_word(kind_type op, int lock_sel, int thread_sel);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= op;
      req_lock_index <= LOCK_W'(lock_sel);
      req_thread_id  <= THREAD_W'(thread_sel);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      lock_model.note_request(op, LOCK_W'(lock_sel), THREAD_W'(thread_sel));
      words_sent++;
      if (op == KIND_ACQUIRE) acquires_sent++;
   endtask

   task automatic directed_words();
      // grant at the low extremes, then a repeat grant by the owner
      send_word(KIND_ACQUIRE, 0, 0);
      send_word(KIND_ACQUIRE, 0, 0);
      // two waiters, then the first waiter asks again
      send_word(KIND_ACQUIRE, 0, 15);
      send_word(KIND_ACQUIRE, 0, 7);
      send_word(KIND_ACQUIRE, 0, 15);
      // a waiter grabs a free lock elsewhere, and another waiter is refused
      send_word(KIND_ACQUIRE, 15, 15);
      send_word(KIND_ACQUIRE, 15, 3);
      send_word(KIND_ACQUIRE, 15, 7);
      // release by a stranger hands over in fifo order, then frees
      send_word(KIND_RELEASE, 0, 9);
      send_word(KIND_RELEASE, 0, 15);
      send_word(KIND_RELEASE, 0, 7);
      // release of a lock that is already free, then lock 15 hands over, frees and is released while free
      send_word(KIND_RELEASE, 0, 0);
      send_word(KIND_RELEASE, 15, 0);
      send_word(KIND_RELEASE, 15, 3);
      send_word(KIND_RELEASE, 15, 15);
      // mid-range ids and a lock that was never touched
      send_word(KIND_RELEASE, 10, 5);
      send_word(KIND_ACQUIRE, 5, 10);
      send_word(KIND_ACQUIRE, 5, 5);
      send_word(KIND_ACQUIRE, 5, 10);
      send_word(KIND_RELEASE, 5, 10);
      send_word(KIND_RELEASE, 5, 5);
   endtask

   // contention on one lock: a burst of acquires, then drain its queue
   task automatic contention_round(int lock_sel);
      int n;
      int drains;
      n = $urandom_range(1, 10);
      repeat (n) send_word(KIND_ACQUIRE, lock_sel, $urandom_range(0, NUM_THREADS_DEF - 1));
      drains = lock_model.waiters[lock_sel] + $urandom_range(0, 2);
      repeat (drains) begin
         if ($urandom_range(0, 7) == 0)
            send_word(KIND_RELEASE, lock_sel, $urandom_range(0, NUM_THREADS_DEF - 1));
         else
            send_word(KIND_RELEASE, lock_sel, lock_model.owner_now(lock_sel));
      end
   endtask

   task automatic random_words(int total);
      int goal;
      goal = words_sent + total;
      while (words_sent < goal) begin
         gaps_on = (goal - words_sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            // noise and broken sequences
            repeat ($urandom_range(1, 10))
               send_word($urandom_range(0, 1) ? KIND_RELEASE : KIND_ACQUIRE,
                         $urandom_range(0, NUM_LOCKS_DEF - 1),
                         $urandom_range(0, NUM_THREADS_DEF - 1));
         end else if ($urandom_range(0, 2) == 0) begin
            contention_round($urandom_range(0, NUM_LOCKS_DEF - 1));
         end else begin
            // a few hot locks keep long queues and cross-lock waiters
            contention_round($urandom_range(0, 3) * 5);
         end
      end
   endtask

   initial begin
      int waited;
      gaps_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_words();
      random_words(RANDOM_WORDS);
      start <= 1'b0;
      // let outstanding words come back
      waited = 0;
      while (lock_model.pending_outcomes.size() > 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lock_model.pending_outcomes.size() > 0) begin
         $display("%0d expected response words never arrived",
                  lock_model.pending_outcomes.size());
         lock_model.failures += lock_model.pending_outcomes.size();
      end
      $display("sent %0d words (%0d acquire), checked %0d responses, %0d mismatches",
               words_sent, acquires_sent, lock_model.checked, lock_model.failures);
      $display("granted %0d queued %0d handed %0d freed %0d, longest wait queue %0d",
               lock_model.status_seen[ST_GRANTED], lock_model.status_seen[ST_QUEUED],
               lock_model.status_seen[ST_HANDED], lock_model.status_seen[ST_FREED],
               lock_model.longest_queue);
      if (lock_model.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop if the handshake hangs
   initial begin
      #(LIMIT_NS);
      $display("timeout after %0d ns", LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
